[hdl/dmxf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX fixture package
// Types, constants and shared arithmetic for the strobe and dimmer core.
// ----------------------------------------------------------------------------
package dmxf_pkg;

   localparam int FOOTPRINT_DEFAULT     = 5;
   localparam int PATTERN_COUNT_DEFAULT = 8;
   localparam int LANES                 = 3;

   localparam logic [15:0] OFF_TIME_BASE     = 16'd51000;
   localparam logic [7:0]  OFF_TIME_SLOPE    = 8'd190;
   localparam logic [7:0]  FULL_LEVEL        = 8'hFF;
   localparam logic [2:0]  DIP_MASK_RED      = 3'h7;
   localparam logic [0:0]  CSR_STROBE_ON_IDX = 1'b0;

   typedef enum logic [1:0] {
      SRC_HOLD,
      SRC_SCALE,
      SRC_LOAD
   } src_type;

   typedef struct packed {
      src_type    sel;
      logic [7:0] value;
   } lane_req_type;

   typedef struct packed {
      logic ld_mult;
      logic ld_out;
   } lane_ctl_type;

   typedef struct packed {
      logic [8:0]                   address;
      logic [7:0]                   master;
      lane_req_type [LANES-1:0]     lanes;
   } stage_type;

   // Red, green, blue of each pattern step.
   localparam logic [23:0] PATTERN_TABLE [8] = '{
      24'h000000,
      24'hFF0000,
      24'h00FF00,
      24'h0000FF,
      24'h808000,
      24'h008080,
      24'h800080,
      24'hFFFFFF
   };

   // Exact quotient by 255 for any value whose quotient fits in eight bits.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [8:0] rem;
      logic [7:0] quo;
      quo = x[15:8];
      rem = {1'b0, x[7:0]} + {1'b0, x[15:8]};
      if (rem >= {1'b0, FULL_LEVEL}) begin
         quo = quo + 8'd1;
      end
      return quo;
   endfunction

endpackage
`default_nettype wire

[hdl/dmx_rgb_fixture_strobe_dimmer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX RGB fixture strobe and dimmer core
// Each request is one pass of the fixture control loop: timer tick, DIP
// switches, microphone event and the five DMX channels go in; the three LED
// levels, the gated master level and the start address come out.
// The request channel (req_) and response channel (rsp_) use valid and
// stall; a transfer happens at a clock edge with valid high and stall low.
// A response passes the control, lane and output registers after acceptance;
// one request is taken in every cycle unless all stages are full and rsp_ stalls.
// The control stage updates all loop state in the cycle of acceptance; three
// colour lanes then multiply by the master level in one stage and divide by
// 255 into the output register, which joins the lanes with the master level
// and address.
// When the receiver stalls, the response register holds and the stages
// behind it keep filling; requests are stalled only once all three stages
// hold a request. The strobe on-time is set through the APB port at byte
// address 0. Reset is synchronous and restores every loop register, the
// colour registers and the strobe on-time of three ticks.
// ----------------------------------------------------------------------------
module dmx_rgb_fixture_strobe_dimmer_core #(
   parameter int FOOTPRINT     = dmxf_pkg::FOOTPRINT_DEFAULT,
   parameter int PATTERN_COUNT = dmxf_pkg::PATTERN_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_tick,
   input  wire logic [8:0]  req_dip_address,
   input  wire logic        req_mode_switch,
   input  wire logic        req_mic_event,
   input  wire logic [7:0]  req_dmx_master,
   input  wire logic [7:0]  req_dmx_strobe,
   input  wire logic [7:0]  req_dmx_red,
   input  wire logic [7:0]  req_dmx_green,
   input  wire logic [7:0]  req_dmx_blue,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_led_red,
   output logic [7:0]       rsp_led_green,
   output logic [7:0]       rsp_led_blue,
   output logic [7:0]       rsp_master_level,
   output logic [8:0]       rsp_start_address
);

   logic [7:0] strobe_on_ff;
   logic       v1_ff, v1_in;
   logic       v2_ff, v2_in;
   logic       v3_ff, v3_in;
   logic       accept, ld2, ld3, rsp_fire;
   logic [7:0] s2_master_ff, out_master_ff;
   logic [8:0] s2_address_ff, out_address_ff;
   logic [7:0] colour [dmxf_pkg::LANES];

   dmxf_pkg::stage_type    stage;
   dmxf_pkg::lane_ctl_type lane_ctl;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == dmxf_pkg::CSR_STROBE_ON_IDX) ? {24'd0, strobe_on_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_on_ff <= 8'd3;
      end else if (psel && penable && pwrite && pready
                   && (paddr[2] == dmxf_pkg::CSR_STROBE_ON_IDX)) begin
         strobe_on_ff <= pwdata[7:0];
      end
   end

   always_comb begin
      rsp_fire  = v3_ff && !rsp_stall;
      ld3       = v2_ff && (!v3_ff || !rsp_stall);
      ld2       = v1_ff && (!v2_ff || ld3);
      req_stall = v1_ff && !ld2;
      accept    = req_valid && !req_stall;
      v1_in     = accept || (v1_ff && !ld2);
      v2_in     = ld2 || (v2_ff && !ld3);
      v3_in     = ld3 || (v3_ff && !rsp_fire);
      lane_ctl  = '{ld_mult: ld2, ld_out: ld3};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   dmxf_ctrl #(
      .FOOTPRINT     (FOOTPRINT),
      .PATTERN_COUNT (PATTERN_COUNT)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .tick            (req_tick),
      .dip_address     (req_dip_address),
      .mode_switch     (req_mode_switch),
      .mic_event       (req_mic_event),
      .dmx_master      (req_dmx_master),
      .dmx_strobe      (req_dmx_strobe),
      .dmx_red         (req_dmx_red),
      .dmx_green       (req_dmx_green),
      .dmx_blue        (req_dmx_blue),
      .strobe_on_ticks (strobe_on_ff),
      .stage           (stage)
   );

   for (genvar g = 0; g < dmxf_pkg::LANES; g++) begin : g_lane
      dmxf_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .lane_req (stage.lanes[g]),
         .master   (stage.master),
         .colour   (colour[g])
      );
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_master_ff  <= stage.master;
         s2_address_ff <= stage.address;
      end
      if (ld3) begin
         out_master_ff  <= s2_master_ff;
         out_address_ff <= s2_address_ff;
      end
   end

   assign rsp_valid         = v3_ff;
   assign rsp_led_red       = colour[0];
   assign rsp_led_green     = colour[1];
   assign rsp_led_blue      = colour[2];
   assign rsp_master_level  = out_master_ff;
   assign rsp_start_address = out_address_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("request stalled while a pipeline stage was free");

   a_fill_behind_stall: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff) |-> !req_stall)
      else $error("request stalled with an empty front of pipeline");

   a_address_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_start_address != 9'd0)
                     && (rsp_start_address <= 9'(512 - FOOTPRINT))))
      else $error("start address outside the permitted range");

   a_response_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_led_red)
                                    && $stable(rsp_led_green) && $stable(rsp_led_blue)
                                    && $stable(rsp_master_level)
                                    && $stable(rsp_start_address)))
      else $error("output stage reloaded while the response was stalled");

endmodule
`default_nettype wire

[hdl/dmxf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX fixture control stage
// Follows the DIP switches, runs the strobe timing and master gating, and
// chooses the colour source for each lane. Updates its state per request.
// ----------------------------------------------------------------------------
module dmxf_ctrl #(
   parameter int FOOTPRINT     = dmxf_pkg::FOOTPRINT_DEFAULT,
   parameter int PATTERN_COUNT = dmxf_pkg::PATTERN_COUNT_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                tick,
   input  wire logic [8:0]          dip_address,
   input  wire logic                mode_switch,
   input  wire logic                mic_event,
   input  wire logic [7:0]          dmx_master,
   input  wire logic [7:0]          dmx_strobe,
   input  wire logic [7:0]          dmx_red,
   input  wire logic [7:0]          dmx_green,
   input  wire logic [7:0]          dmx_blue,
   input  wire logic [7:0]          strobe_on_ticks,
   output dmxf_pkg::stage_type      stage
);

   localparam logic [8:0] ADDR_MAX = 9'(512 - FOOTPRINT);

   logic       dmx_mode_ff, dmx_mode_in;
   logic       dip_seen_ff;
   logic [8:0] dip_cache_ff;
   logic [8:0] address_ff, address_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic       flash_lit_ff, flash_lit_in;
   logic       strobe_was_ff, strobe_was_in;
   logic [7:0] master_ff, master_in;
   logic [2:0] pattern_ff, pattern_in;
   dmxf_pkg::stage_type stage_ff, stage_in;

   logic        refresh;
   logic        dip_changed;
   logic        strobe_on;
   logic [15:0] off_num;
   logic [7:0]  off_ticks;
   logic [3:0]  pattern_next;
   logic [23:0] pattern_rgb;
   logic [7:0]  static_red, static_green, static_blue;

   always_comb begin
      off_num   = dmxf_pkg::OFF_TIME_BASE
                - ({8'd0, dmxf_pkg::OFF_TIME_SLOPE} * {8'd0, dmx_strobe});
      off_ticks = dmxf_pkg::div255(off_num);
   end

   always_comb begin
      static_red   = {dip_address[2:0] & dmxf_pkg::DIP_MASK_RED, 5'd0};
      static_green = {dip_address[5:3], 5'd0};
      static_blue  = {dip_address[7:6], 6'd0};
      pattern_next = {1'b0, pattern_ff} + 4'd1;
      if (32'(pattern_next) >= PATTERN_COUNT) begin
         pattern_next = 4'd0;
      end
      pattern_rgb = dmxf_pkg::PATTERN_TABLE[pattern_next[2:0]];
   end

   always_comb begin
      tick_count_in = tick_count_ff;
      if (tick && (tick_count_ff != dmxf_pkg::FULL_LEVEL)) begin
         tick_count_in = tick_count_ff + 8'd1;
      end

      dmx_mode_in   = mode_switch;
      refresh       = (mode_switch != dmx_mode_ff) && !mode_switch;
      dip_changed   = !dip_seen_ff || (dip_address != dip_cache_ff);
      address_in    = address_ff;
      master_in     = master_ff;
      flash_lit_in  = flash_lit_ff;
      strobe_was_in = strobe_was_ff;
      pattern_in    = pattern_ff;
      strobe_on     = (dmx_strobe != 8'd0);

      stage_in = '0;
      for (int i = 0; i < dmxf_pkg::LANES; i++) begin
         stage_in.lanes[i].sel = dmxf_pkg::SRC_HOLD;
      end

      if (dip_changed) begin
         if (dip_address == 9'd0) begin
            address_in = 9'd1;
         end else if (dip_address > ADDR_MAX) begin
            address_in = ADDR_MAX;
         end else begin
            address_in = dip_address;
         end
         if (!mode_switch) begin
            refresh = 1'b1;
         end
      end

      if (refresh) begin
         master_in = dmxf_pkg::FULL_LEVEL;
         stage_in.lanes[0] = '{sel: dmxf_pkg::SRC_LOAD, value: static_red};
         stage_in.lanes[1] = '{sel: dmxf_pkg::SRC_LOAD, value: static_green};
         stage_in.lanes[2] = '{sel: dmxf_pkg::SRC_LOAD, value: static_blue};
      end

      if (mode_switch) begin
         if (!strobe_was_ff && strobe_on) begin
            tick_count_in = 8'd0;
            flash_lit_in  = 1'b1;
         end
         strobe_was_in = strobe_on;
         if (strobe_on) begin
            if (flash_lit_in) begin
               if (tick_count_in >= strobe_on_ticks) begin
                  master_in     = 8'd0;
                  flash_lit_in  = 1'b0;
                  tick_count_in = 8'd0;
               end else begin
                  master_in = dmx_master;
               end
            end else begin
               if (tick_count_in > off_ticks) begin
                  master_in     = dmx_master;
                  flash_lit_in  = 1'b1;
                  tick_count_in = 8'd0;
               end else begin
                  master_in = 8'd0;
               end
            end
         end else begin
            master_in = dmx_master;
         end
         stage_in.lanes[0] = '{sel: dmxf_pkg::SRC_SCALE, value: dmx_red};
         stage_in.lanes[1] = '{sel: dmxf_pkg::SRC_SCALE, value: dmx_green};
         stage_in.lanes[2] = '{sel: dmxf_pkg::SRC_SCALE, value: dmx_blue};
      end else if ((dip_address == 9'd0) && mic_event) begin
         pattern_in = pattern_next[2:0];
         stage_in.lanes[0] = '{sel: dmxf_pkg::SRC_LOAD, value: pattern_rgb[23:16]};
         stage_in.lanes[1] = '{sel: dmxf_pkg::SRC_LOAD, value: pattern_rgb[15:8]};
         stage_in.lanes[2] = '{sel: dmxf_pkg::SRC_LOAD, value: pattern_rgb[7:0]};
      end

      stage_in.master  = master_in;
      stage_in.address = address_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dmx_mode_ff   <= 1'b1;
         dip_seen_ff   <= 1'b0;
         dip_cache_ff  <= 9'd0;
         address_ff    <= 9'd1;
         tick_count_ff <= 8'd0;
         flash_lit_ff  <= 1'b0;
         strobe_was_ff <= 1'b0;
         master_ff     <= 8'd0;
         pattern_ff    <= 3'd0;
      end else if (accept) begin
         dmx_mode_ff   <= dmx_mode_in;
         dip_seen_ff   <= 1'b1;
         dip_cache_ff  <= dip_address;
         address_ff    <= address_in;
         tick_count_ff <= tick_count_in;
         flash_lit_ff  <= flash_lit_in;
         strobe_was_ff <= strobe_was_in;
         master_ff     <= master_in;
         pattern_ff    <= pattern_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule
`default_nettype wire

[hdl/dmxf_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX fixture colour lane
// Scales one colour channel by the master level over two stages and keeps
// the colour register, which holds its value when no new source is chosen.
// ----------------------------------------------------------------------------
module dmxf_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  dmxf_pkg::lane_ctl_type      ctl,
   input  dmxf_pkg::lane_req_type      lane_req,
   input  wire logic [7:0]             master,
   output logic [7:0]                  colour
);

   dmxf_pkg::src_type sel_ff;
   logic [7:0]        value_ff;
   logic [15:0]       product_ff;
   logic [7:0]        colour_ff, colour_in;

   always_ff @(posedge clock) begin
      if (ctl.ld_mult) begin
         sel_ff     <= lane_req.sel;
         value_ff   <= lane_req.value;
         product_ff <= {8'd0, lane_req.value} * {8'd0, master};
      end
   end

   always_comb begin
      case (sel_ff)
         dmxf_pkg::SRC_SCALE: colour_in = dmxf_pkg::div255(product_ff);
         dmxf_pkg::SRC_LOAD:  colour_in = value_ff;
         default:             colour_in = colour_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= 8'd0;
      end else if (ctl.ld_out) begin
         colour_ff <= colour_in;
      end
   end

   assign colour = colour_ff;

endmodule
`default_nettype wire
